>>> rtl/csc_pkg.sv
package csc_pkg;

    localparam int ANGLE_W        = 32;
    localparam int OUT_W          = 18;
    localparam int OUT_DATA_W     = 40;
    localparam int ZW             = 20;
    localparam int XW             = 20;
    localparam int QW             = 13;
    localparam int TABLE_LEN      = 17;
    localparam int ITERATIONS_DEF = 16;

    localparam int RECIP_SHIFT = 44;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd411775);

    localparam logic [31:0]          TWO_PI_U  = 32'd411775;
    localparam logic [ZW-1:0]        TWO_PI_R  = 20'd411775;
    localparam logic signed [ZW-1:0] PI_Z      = 20'sd205887;
    localparam logic signed [ZW-1:0] TWO_PI_Z  = 20'sd411775;
    localparam logic signed [ZW-1:0] HALF_PI_Z = 20'sd102944;
    localparam logic signed [XW-1:0] CORDIC_K  = 20'sd39797;
    localparam logic signed [XW-1:0] OUT_MAX   = 20'sd131071;
    localparam logic signed [XW-1:0] OUT_MIN   = -20'sd131072;

    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 20'sd51471;
            1:       v = 20'sd30385;
            2:       v = 20'sd16061;
            3:       v = 20'sd8152;
            4:       v = 20'sd4093;
            5:       v = 20'sd2048;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            16:      v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [XW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cordic_sine_cosine_q16.sv
// Sine and cosine of a Q16.16 angle (radians) by rotation-mode CORDIC.
// Slave channel: s_tdata[31:0] carries the signed Q16.16 angle, one per beat.
// Master channel: m_tdata carries sine and cosine, both signed Q2.16 in 18 bits.
// The angle is reduced modulo two pi (sign of the input kept), wrapped into
// [-pi, pi] and folded into [-pi/2, pi/2]; a fold negates the cosine.
// Pipeline: abs, reciprocal multiply, quotient multiply, remainder, wrap/fold,
// one stage per CORDIC iteration, and an output register.
// Throughput: one beat per cycle while m_tready is high, set by one CORDIC iteration per stage.
// Each stage holds its beat while the stage after it is full and stalled;
// empty stages still fill, so s_tready stays high until the whole pipe is full.
// Nothing is lost or repeated while m_tready is low.
// Reset clears every valid bit; the pipe comes out of reset empty and ready.
module cordic_sine_cosine_q16 #(
    parameter int ITERATIONS = csc_pkg::ITERATIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [csc_pkg::ANGLE_W-1:0]     s_tdata,  // [31:0] angle
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [csc_pkg::OUT_DATA_W-1:0]  m_tdata   // [17:0] sine, [35:18] cosine
);
    import csc_pkg::*;

    localparam int N  = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    localparam int NS = N + 6;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   rdy;

    logic [31:0]      a_mag_reg;
    logic             a_neg_reg;
    logic [QW-1:0]    b_q_reg;
    logic [31:0]      b_mag_reg;
    logic             b_neg_reg;
    logic [31:0]      c_qp_reg;
    logic [31:0]      c_mag_reg;
    logic             c_neg_reg;
    logic signed [ZW-1:0] d_rem_reg;

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 nc_reg [0:N];

    logic signed [OUT_W-1:0] sine_reg;
    logic signed [OUT_W-1:0] cosine_reg;

    logic [31:0]                  a_mag_next;
    logic [RECIP_W+31:0]          prod;
    logic [31:0]                  qp;
    logic [31:0]                  diff;
    logic [ZW-1:0]                r_corr;
    logic signed [ZW-1:0]         d_rem_next;
    logic signed [ZW-1:0]         wrapped;
    logic signed [ZW-1:0]         z_fold;
    logic                         nc_fold;
    logic signed [XW-1:0]         x_fin;

    always_comb
    begin
        rdy[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = s_tvalid;
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, cosine_reg, sine_reg};

    // magnitude, |-2^31| fits unsigned
    assign a_mag_next = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_mag_reg <= a_mag_next;
            a_neg_reg <= s_tdata[31];
        end
    end

    // quotient estimate: exact or one low
    assign prod = {{RECIP_W{1'b0}}, a_mag_reg} * {32'd0, RECIP};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b_q_reg   <= prod[RECIP_SHIFT+QW-1:RECIP_SHIFT];
            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
        end
    end

    assign qp = {{(32-QW){1'b0}}, b_q_reg} * TWO_PI_U;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            c_qp_reg  <= qp;
            c_mag_reg <= b_mag_reg;
            c_neg_reg <= b_neg_reg;
        end
    end

    always_comb
    begin
        diff   = c_mag_reg - c_qp_reg;
        r_corr = (diff[ZW-1:0] >= TWO_PI_R) ? (diff[ZW-1:0] - TWO_PI_R) : diff[ZW-1:0];
        d_rem_next = c_neg_reg ? -$signed(r_corr) : $signed(r_corr);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            d_rem_reg <= d_rem_next;
        end
    end

    always_comb
    begin
        if (d_rem_reg > PI_Z)
        begin
            wrapped = d_rem_reg - TWO_PI_Z;
        end
        else if (d_rem_reg < -PI_Z)
        begin
            wrapped = d_rem_reg + TWO_PI_Z;
        end
        else
        begin
            wrapped = d_rem_reg;
        end

        if (wrapped > HALF_PI_Z)
        begin
            z_fold  = PI_Z - wrapped;
            nc_fold = 1'b1;
        end
        else if (wrapped < -HALF_PI_Z)
        begin
            z_fold  = -PI_Z - wrapped;
            nc_fold = 1'b1;
        end
        else
        begin
            z_fold  = wrapped;
            nc_fold = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            x_reg[0]  <= CORDIC_K;
            y_reg[0]  <= '0;
            z_reg[0]  <= z_fold;
            nc_reg[0] <= nc_fold;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = atan_step(i);
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (rdy[5+i])
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                nc_reg[i+1] <= nc_reg[i];
            end
        end
    end

    assign x_fin = nc_reg[N] ? -x_reg[N] : x_reg[N];

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            sine_reg   <= sat_out(y_reg[N]);
            cosine_reg <= sat_out(x_fin);
        end
    end

endmodule
